// ===== rtl/core/fbc_pkg.sv =====
package fbc_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned MsW    = 42;  // 32-bit seconds times 1000 fits in 42 bits
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [MsW-1:0] MsPerSec = MsW'(1000);

  // commands
  localparam logic [CmdW-1:0] CmdQuery   = 3'd0;
  localparam logic [CmdW-1:0] CmdRequest = 3'd1;
  localparam logic [CmdW-1:0] CmdHealth  = 3'd2;
  localparam logic [CmdW-1:0] CmdSent    = 3'd3;
  localparam logic [CmdW-1:0] CmdTimeout = 3'd4;
  localparam logic [CmdW-1:0] CmdAck     = 3'd5;
  localparam logic [CmdW-1:0] CmdElect   = 3'd6;
  localparam logic [CmdW-1:0] CmdLeader  = 3'd7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRecoveryStable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXferTimeout    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegProbation      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBackoffReset   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBackoffFirst   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBackoffSecond  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBackoffThird   = 3'd6;

  // request kinds
  localparam logic [1:0] ReqNone   = 2'd0;
  localparam logic [1:0] ReqNormal = 2'd1;
  localparam logic [1:0] ReqForced = 2'd2;

  localparam logic [1:0] TopLevel = 2'd3;

  // configuration, second values already in milliseconds
  typedef struct packed {
    logic [MsW-1:0]  stable_ms;
    logic [CfgW-1:0] timeout;
    logic [MsW-1:0]  probation_ms;
    logic [MsW-1:0]  reset_ms;
    logic [MsW-1:0]  first_ms;
    logic [MsW-1:0]  second_ms;
    logic [MsW-1:0]  third_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       req_kind;
    logic             xfer_pending;
    logic [TimeW-1:0] xfer_since;
    logic [TimeW-1:0] stable_since;
    logic [TimeW-1:0] hold_until;
    logic [TimeW-1:0] probation_end;
    logic [TimeW-1:0] clear_at;
    logic [1:0]       backoff_step;
  } state_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [TimeW-1:0] now_time;
    logic             force_req;
    logic             primary_ok;
    logic             in_sync;
    logic             primary_leads;
  } item_t;

  typedef struct packed {
    logic       pending;
    logic [1:0] level;
    logic       fired;
    logic       waiting;
    logic       ready_res;
  } result_t;

endpackage

// ===== rtl/core/fbc_step.sv =====
module fbc_step import fbc_pkg::*; (
  input  state_t  st_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output state_t  st_o,
  output result_t res_o
);

  state_t           n;
  logic             fired;
  logic [1:0]       step_up;
  logic [MsW-1:0]   raise_ms;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] raise_hold;
  logic [TimeW-1:0] prob_end;
  logic [TimeW-1:0] reset_at;
  logic [TimeW-1:0] pend;
  logic             timed_out;
  logic             ready;

  assign now = item_i.now_time;

  // backoff raise: saturating level and its hold-off
  always_comb begin
    step_up = (st_i.backoff_step == TopLevel) ? TopLevel : st_i.backoff_step + 2'd1;
    if (step_up == 2'd1) begin
      raise_ms = cfg_i.first_ms;
    end else if (step_up == 2'd2) begin
      raise_ms = cfg_i.second_ms;
    end else begin
      raise_ms = cfg_i.third_ms;
    end
  end

  assign raise_hold = now + TimeW'(raise_ms);
  assign prob_end   = now + TimeW'(cfg_i.probation_ms);
  assign reset_at   = now + TimeW'(cfg_i.reset_ms);
  assign timed_out  = (now - st_i.xfer_since) >= TimeW'(cfg_i.timeout);

  always_comb begin
    n     = st_i;
    fired = 1'b0;
    pend  = st_i.probation_end;
    unique case (item_i.command)
      CmdRequest: begin
        n.req_kind = item_i.force_req ? ReqForced : ReqNormal;
      end
      CmdHealth: begin
        if (!item_i.primary_ok) begin
          n.stable_since = '0;
        end else if (st_i.stable_since == '0) begin
          n.stable_since = now;
        end
      end
      CmdSent: begin
        n.req_kind     = ReqNone;
        n.xfer_pending = 1'b1;
        n.xfer_since   = now;
      end
      CmdTimeout: begin
        if (st_i.xfer_pending && timed_out) begin
          n.xfer_pending = 1'b0;
          n.xfer_since   = '0;
          n.backoff_step = step_up;
          n.hold_until   = raise_hold;
          n.clear_at     = '0;
          fired          = 1'b1;
        end
      end
      CmdAck: begin
        n.xfer_pending  = 1'b0;
        n.xfer_since    = '0;
        n.probation_end = prob_end;
        n.clear_at      = '0;
      end
      CmdElect: begin
        if (st_i.probation_end != '0 && now < st_i.probation_end) begin
          n.backoff_step = step_up;
          n.hold_until   = raise_hold;
          fired          = 1'b1;
        end
        n.stable_since  = '0;
        n.probation_end = '0;
        n.clear_at      = '0;
        n.xfer_pending  = 1'b0;
        n.xfer_since    = '0;
      end
      CmdLeader: begin
        if (!item_i.primary_leads || !item_i.primary_ok) begin
          n.clear_at = '0;
        end else begin
          if (st_i.xfer_pending) begin
            n.xfer_pending = 1'b0;
            n.xfer_since   = '0;
            if (pend == '0) begin
              pend = prob_end;
            end
          end
          n.probation_end = pend;
          // still on probation: nothing more to do
          if (pend == '0 || now >= pend) begin
            n.probation_end = '0;
            if (st_i.backoff_step != 2'd0) begin
              if (st_i.clear_at == '0) begin
                n.clear_at = reset_at;
              end else if (now >= st_i.clear_at) begin
                n.backoff_step = 2'd0;
                n.hold_until   = '0;
                n.clear_at     = '0;
              end
            end
          end
        end
      end
      default: begin
        // query: outputs only
      end
    endcase
  end

  // readiness is judged on the state after the event
  always_comb begin
    if (n.xfer_pending || !item_i.primary_ok || !item_i.in_sync) begin
      ready = 1'b0;
    end else if (n.req_kind == ReqForced) begin
      ready = 1'b1;
    end else if (n.stable_since == '0 ||
                 (now - n.stable_since) < TimeW'(cfg_i.stable_ms) ||
                 now < n.hold_until) begin
      ready = 1'b0;
    end else begin
      ready = 1'b1;
    end
  end

  assign st_o            = n;
  assign res_o.ready_res = ready;
  assign res_o.waiting   = n.xfer_pending &&
                           ((now - n.xfer_since) < TimeW'(cfg_i.timeout));
  assign res_o.fired     = fired;
  assign res_o.level     = n.backoff_step;
  assign res_o.pending   = n.xfer_pending;

endmodule

// ===== rtl/core/failback_backoff_controller.sv =====
// Failback controller with three-level backoff for a primary/backup pair.
//
// Event items arrive on the s_axis side: tuser carries the command, tdata
// the timestamp and the observation flags. Each accepted item produces
// exactly one result item on the m_axis side (readiness, waiting, fired,
// backoff level, pending).
//
// An accepted item sits in the input register until the result register is
// free, is then loaded into the result register, which raises m_axis_tvalid,
// and the result is held there until m_axis_tready takes it.
// Throughput: one item per cycle while m_axis does not stall; the controller
// state is updated together with the result register, so back-to-back events
// see each other's effects.
//
// The cfg_* port writes the seven timing registers; second-valued ones are
// scaled to milliseconds as they are written (one 32x10 multiply into the
// register), so the stored values are already in milliseconds.
//
// Reset clears all state and configuration to zero. When m_axis stalls the
// result is held; one further item may wait in the input register, after
// which s_axis_tready drops until the result is taken.
module failback_backoff_controller import fbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // event items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [71:0]        s_axis_tdata,  // now_time[63:0], force_req, primary_ok,
                                            // in_sync, primary_leads, zero pad
  input  logic [CmdW-1:0]    s_axis_tuser,  // command
  // result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata   // ready_res, waiting, fired, level[1:0],
                                            // pending, zero pad
);

  cfg_t    cfg_q;
  state_t  st_q, st_d;
  item_t   item_q;
  logic    in_vld_q;
  result_t res_q, res_d;
  logic    out_vld_q;
  logic    advance;
  logic    s_acc;
  logic [MsW-1:0] wr_ms;

  // item moves from input register to result register when the latter is free
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // seconds to milliseconds on the write path
  assign wr_ms = MsW'(cfg_wdata_i) * MsPerSec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRecoveryStable: cfg_q.stable_ms    <= wr_ms;
        RegXferTimeout:    cfg_q.timeout      <= cfg_wdata_i;
        RegProbation:      cfg_q.probation_ms <= wr_ms;
        RegBackoffReset:   cfg_q.reset_ms     <= wr_ms;
        RegBackoffFirst:   cfg_q.first_ms     <= wr_ms;
        RegBackoffSecond:  cfg_q.second_ms    <= wr_ms;
        RegBackoffThird:   cfg_q.third_ms     <= wr_ms;
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q.command       <= s_axis_tuser;
      item_q.now_time      <= s_axis_tdata[63:0];
      item_q.force_req     <= s_axis_tdata[64];
      item_q.primary_ok    <= s_axis_tdata[65];
      item_q.in_sync       <= s_axis_tdata[66];
      item_q.primary_leads <= s_axis_tdata[67];
    end
  end

  fbc_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // controller state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q.pending, res_q.level, res_q.fired,
                          res_q.waiting, res_q.ready_res};

endmodule
